// File: design/rgg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgg_pkg
// Shared constants and types for the rgb to gray converter with 3x3 smoothing.
// ----------------------------------------------------------------------------
package rgg_pkg;

    // frame geometry
    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = 16;
    localparam int PIX_W     = 8;

    // result field widths
    localparam int OUT_COL_W = 11;

    // configuration port
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int WIDTH_CFG_W  = 12;
    localparam int HEIGHT_CFG_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;

    // truncated Q16 luma weights
    localparam int LUMA_FRAC_W = 16;
    localparam int PROD_W      = LUMA_FRAC_W + PIX_W;
    localparam logic [LUMA_FRAC_W-1:0] WEIGHT_RED   = 16'd19595;
    localparam logic [LUMA_FRAC_W-1:0] WEIGHT_GREEN = 16'd38469;
    localparam logic [LUMA_FRAC_W-1:0] WEIGHT_BLUE  = 16'd7471;

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // result queue inside the back part
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    // smoothing sum: kernel weights add up to 16
    localparam int BLUR_SUM_W = PIX_W + 4;

    // line store word: older row byte above newer row byte
    localparam int LS_W = 2 * PIX_W;

    // one classified pixel on its way from front to back
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [PIX_W-1:0] gray;
        logic             interior;
        logic             border;
        logic             done;
    } rgg_item_t;

endpackage

// File: design/rgg_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgg_queue
// Short first-in first-out queue of classified pixels between front and back.
// ----------------------------------------------------------------------------
module rgg_queue (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  rgg_pkg::rgg_item_t         push_item,
    input  logic                       pop,
    output logic                       not_empty,
    output rgg_pkg::rgg_item_t         head_item,
    output logic [rgg_pkg::Q_CNT_W-1:0] fill
);

    rgg_pkg::rgg_item_t               slot_reg [rgg_pkg::Q_DEPTH];
    logic [rgg_pkg::Q_PTR_W-1:0]      wptr_reg;
    logic [rgg_pkg::Q_PTR_W-1:0]      rptr_reg;
    logic [rgg_pkg::Q_CNT_W-1:0]      count_reg;
    logic [rgg_pkg::Q_PTR_W-1:0]      wptr_next;
    logic [rgg_pkg::Q_PTR_W-1:0]      rptr_next;
    logic [rgg_pkg::Q_CNT_W-1:0]      count_next;

    // pointer and fill bookkeeping
    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push) begin
            wptr_next = (wptr_reg == rgg_pkg::Q_PTR_W'(rgg_pkg::Q_DEPTH - 1)) ?
                        '0 : wptr_reg + rgg_pkg::Q_PTR_W'(1);
        end
        if (pop) begin
            rptr_next = (rptr_reg == rgg_pkg::Q_PTR_W'(rgg_pkg::Q_DEPTH - 1)) ?
                        '0 : rptr_reg + rgg_pkg::Q_PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + rgg_pkg::Q_CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - rgg_pkg::Q_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // storage, no reset needed
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wptr_reg] <= push_item;
        end
    end

    assign not_empty = (count_reg != '0);
    assign head_item = slot_reg[rptr_reg];
    assign fill      = count_reg;

    // front must never push into a full queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |-> count_reg < rgg_pkg::Q_CNT_W'(rgg_pkg::Q_DEPTH))
        else $error("rgg_queue: push into full queue");

endmodule

// File: design/rgg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgg_front
// Accepts rgb words, tracks column and row, classifies each pixel and
// converts it to luma over two stages before handing it to the queue.
// ----------------------------------------------------------------------------
module rgg_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [rgg_pkg::PIX_W-1:0]        s_red,
    input  logic [rgg_pkg::PIX_W-1:0]        s_green,
    input  logic [rgg_pkg::PIX_W-1:0]        s_blue,
    input  logic                             cfg_wr_en,
    input  logic [rgg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rgg_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  logic [rgg_pkg::Q_CNT_W-1:0]      q_fill,
    output logic                             q_push,
    output rgg_pkg::rgg_item_t               q_item
);

    logic                                s_accept;
    logic [rgg_pkg::Q_CNT_W:0]           q_occ;

    // frame geometry, kept as last column and last row
    logic [rgg_pkg::COL_W-1:0]           w_last_reg;
    logic [rgg_pkg::ROW_W-1:0]           h_last_reg;
    logic [rgg_pkg::COL_W-1:0]           w_last_next;
    logic [rgg_pkg::ROW_W-1:0]           h_last_next;
    logic [rgg_pkg::WIDTH_CFG_W-1:0]     w_cfg;
    logic [rgg_pkg::HEIGHT_CFG_W-1:0]    h_cfg;

    // raster position of the next pixel
    logic [rgg_pkg::COL_W-1:0]           col_reg;
    logic [rgg_pkg::ROW_W-1:0]           row_reg;

    // first stage: raw word and its class
    logic                                f1_valid_reg;
    logic [rgg_pkg::PIX_W-1:0]           f1_red_reg;
    logic [rgg_pkg::PIX_W-1:0]           f1_green_reg;
    logic [rgg_pkg::PIX_W-1:0]           f1_blue_reg;
    rgg_pkg::rgg_item_t                  f1_item_reg;

    // second stage: weighted components
    logic                                f2_valid_reg;
    logic [rgg_pkg::PROD_W-1:0]          f2_pr_reg;
    logic [rgg_pkg::PROD_W-1:0]          f2_pg_reg;
    logic [rgg_pkg::PROD_W-1:0]          f2_pb_reg;
    rgg_pkg::rgg_item_t                  f2_item_reg;

    logic [rgg_pkg::PROD_W:0]            luma_sum;
    logic                                is_last_col;
    logic                                is_last_row;

    // credit check: queue slots must cover every word still in flight
    assign q_occ    = (rgg_pkg::Q_CNT_W + 1)'(q_fill)
                    + (rgg_pkg::Q_CNT_W + 1)'(f1_valid_reg)
                    + (rgg_pkg::Q_CNT_W + 1)'(f2_valid_reg);
    assign s_ready  = q_occ < (rgg_pkg::Q_CNT_W + 1)'(rgg_pkg::Q_DEPTH);
    assign s_accept = s_valid && s_ready;

    // clamp the written geometry
    always_comb begin
        w_cfg = cfg_wr_data[rgg_pkg::WIDTH_CFG_W-1:0];
        h_cfg = cfg_wr_data[rgg_pkg::HEIGHT_CFG_W-1:0];
        if (w_cfg == '0) begin
            w_last_next = '0;
        end else if (int'(w_cfg) > rgg_pkg::MAX_WIDTH) begin
            w_last_next = rgg_pkg::COL_W'(rgg_pkg::MAX_WIDTH - 1);
        end else begin
            w_last_next = rgg_pkg::COL_W'(w_cfg - rgg_pkg::WIDTH_CFG_W'(1));
        end
        h_last_next = (h_cfg == '0) ? '0 : h_cfg - rgg_pkg::HEIGHT_CFG_W'(1);
    end

    assign is_last_col = (col_reg == w_last_reg);
    assign is_last_row = (row_reg == h_last_reg);

    // geometry registers and raster counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_last_reg <= rgg_pkg::COL_W'(rgg_pkg::WIDTH_RESET - 1);
            h_last_reg <= rgg_pkg::ROW_W'(rgg_pkg::HEIGHT_RESET - 1);
            col_reg    <= '0;
            row_reg    <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                rgg_pkg::CFG_IMAGE_WIDTH: begin
                    w_last_reg <= w_last_next;
                    col_reg    <= '0;
                    row_reg    <= '0;
                end
                rgg_pkg::CFG_IMAGE_HEIGHT: begin
                    h_last_reg <= h_last_next;
                    col_reg    <= '0;
                    row_reg    <= '0;
                end
                default: begin
                end
            endcase
        end else if (s_accept) begin
            if (is_last_col) begin
                col_reg <= '0;
                row_reg <= is_last_row ? '0 : row_reg + rgg_pkg::ROW_W'(1);
            end else begin
                col_reg <= col_reg + rgg_pkg::COL_W'(1);
            end
        end
    end

    // stage valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end else begin
            f1_valid_reg <= s_accept;
            f2_valid_reg <= f1_valid_reg;
        end
    end

    // capture and classify the accepted word
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            f1_red_reg           <= s_red;
            f1_green_reg         <= s_green;
            f1_blue_reg          <= s_blue;
            f1_item_reg.col      <= col_reg;
            f1_item_reg.row      <= row_reg;
            f1_item_reg.gray     <= '0;
            f1_item_reg.interior <= (col_reg >= rgg_pkg::COL_W'(2))
                                 && (row_reg >= rgg_pkg::ROW_W'(2));
            f1_item_reg.border   <= (row_reg == '0) || is_last_row
                                 || (col_reg == '0) || is_last_col;
            f1_item_reg.done     <= is_last_col && is_last_row;
        end
    end

    // weight the components
    always_ff @(posedge aclk) begin
        if (f1_valid_reg) begin
            f2_pr_reg   <= rgg_pkg::PROD_W'(rgg_pkg::WEIGHT_RED * f1_red_reg);
            f2_pg_reg   <= rgg_pkg::PROD_W'(rgg_pkg::WEIGHT_GREEN * f1_green_reg);
            f2_pb_reg   <= rgg_pkg::PROD_W'(rgg_pkg::WEIGHT_BLUE * f1_blue_reg);
            f2_item_reg <= f1_item_reg;
        end
    end

    // add and drop the fraction
    assign luma_sum = (rgg_pkg::PROD_W + 1)'(f2_pr_reg)
                    + (rgg_pkg::PROD_W + 1)'(f2_pg_reg)
                    + (rgg_pkg::PROD_W + 1)'(f2_pb_reg);

    always_comb begin
        q_item      = f2_item_reg;
        q_item.gray = luma_sum[rgg_pkg::LUMA_FRAC_W +: rgg_pkg::PIX_W];
    end

    assign q_push = f2_valid_reg;

endmodule

// File: design/rgg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgg_back
// Runs the line stores and the 3x3 window, forms the smoothed value and
// queues up to two results per pixel for the result port.
// ----------------------------------------------------------------------------
module rgg_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             q_valid,
    input  rgg_pkg::rgg_item_t               q_head,
    output logic                             q_pop,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [rgg_pkg::OUT_COL_W-1:0]    m_out_col,
    output logic [rgg_pkg::ROW_W-1:0]        m_out_row,
    output logic [rgg_pkg::PIX_W-1:0]        m_gray_value,
    output logic                             m_is_border,
    output logic                             m_last_in_run,
    output logic                             m_frame_done
);

    typedef struct packed {
        logic [rgg_pkg::COL_W-1:0] col;
        logic [rgg_pkg::ROW_W-1:0] row;
        logic [rgg_pkg::PIX_W-1:0] gray;
        logic [rgg_pkg::PIX_W-1:0] blur;
        logic                      interior;
        logic                      border;
        logic                      done;
    } rgg_out_item_t;

    // line stores: older row in the upper byte, newer row in the lower byte
    logic [rgg_pkg::LS_W-1:0]            lstore_mem [rgg_pkg::MAX_WIDTH];
    logic [rgg_pkg::LS_W-1:0]            rd_data_reg;

    // window stage
    logic                                qv_reg;
    rgg_pkg::rgg_item_t                  q_item_reg;
    logic                                fwd_valid_reg;
    logic [rgg_pkg::COL_W-1:0]           fwd_addr_reg;
    logic [rgg_pkg::LS_W-1:0]            fwd_data_reg;
    logic [rgg_pkg::LS_W-1:0]            line_raw;
    logic [rgg_pkg::PIX_W-1:0]           top_pix;
    logic [rgg_pkg::PIX_W-1:0]           mid_pix;
    logic [rgg_pkg::LS_W-1:0]            wr_data;
    logic [rgg_pkg::PIX_W-1:0]           win_reg [3][3];

    // sum stage
    logic                                sv_reg;
    rgg_pkg::rgg_item_t                  s_item_reg;
    logic [rgg_pkg::BLUR_SUM_W-1:0]      blur_sum;
    logic                                oq_push;
    rgg_out_item_t                       oq_in;

    // result queue
    rgg_out_item_t                       oq_slot_reg [rgg_pkg::OQ_DEPTH];
    logic [rgg_pkg::OQ_PTR_W-1:0]        oq_wptr_reg;
    logic [rgg_pkg::OQ_PTR_W-1:0]        oq_rptr_reg;
    logic [rgg_pkg::OQ_CNT_W-1:0]        oq_count_reg;
    logic [rgg_pkg::OQ_CNT_W:0]          oq_occ;
    logic                                oq_pop;
    logic                                sub_reg;
    logic                                sub_next;
    rgg_out_item_t                       oq_head;
    logic                                show_int;
    logic                                two_step;
    logic                                m_accept;
    logic [rgg_pkg::COL_W-1:0]           res_col;

    // take a pixel only when the result queue has room for all in flight
    assign oq_occ = (rgg_pkg::OQ_CNT_W + 1)'(oq_count_reg)
                  + (rgg_pkg::OQ_CNT_W + 1)'(qv_reg)
                  + (rgg_pkg::OQ_CNT_W + 1)'(sv_reg);
    assign q_pop  = q_valid && (oq_occ < (rgg_pkg::OQ_CNT_W + 1)'(rgg_pkg::OQ_DEPTH));

    // stage valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qv_reg        <= 1'b0;
            sv_reg        <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end else begin
            qv_reg        <= q_pop;
            sv_reg        <= qv_reg;
            fwd_valid_reg <= qv_reg;
        end
    end

    // line store read and write
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            rd_data_reg <= lstore_mem[q_head.col];
        end
        if (qv_reg) begin
            lstore_mem[q_item_reg.col] <= wr_data;
        end
    end

    // forward the write of the previous cycle on a same-column hit,
    // rows not yet seen in this frame read as zero
    always_comb begin
        line_raw = (fwd_valid_reg && (fwd_addr_reg == q_item_reg.col)) ?
                   fwd_data_reg : rd_data_reg;
        top_pix  = (q_item_reg.row >= rgg_pkg::ROW_W'(2)) ?
                   line_raw[rgg_pkg::LS_W-1 -: rgg_pkg::PIX_W] : '0;
        mid_pix  = (q_item_reg.row >= rgg_pkg::ROW_W'(1)) ?
                   line_raw[rgg_pkg::PIX_W-1:0] : '0;
        wr_data  = {mid_pix, q_item_reg.gray};
    end

    // stage payload
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            q_item_reg <= q_head;
        end
        if (qv_reg) begin
            s_item_reg   <= q_item_reg;
            fwd_addr_reg <= q_item_reg.col;
            fwd_data_reg <= wr_data;
        end
    end

    // window shifts left by one column per pixel
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    win_reg[i][j] <= '0;
                end
            end
        end else if (qv_reg) begin
            for (int i = 0; i < 3; i++) begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= top_pix;
            win_reg[1][2] <= mid_pix;
            win_reg[2][2] <= q_item_reg.gray;
        end
    end

    // 1-2-1 / 2-4-2 / 1-2-1 weighted sum
    assign blur_sum =
          rgg_pkg::BLUR_SUM_W'(win_reg[0][0])
        + (rgg_pkg::BLUR_SUM_W'(win_reg[0][1]) << 1)
        + rgg_pkg::BLUR_SUM_W'(win_reg[0][2])
        + (rgg_pkg::BLUR_SUM_W'(win_reg[1][0]) << 1)
        + (rgg_pkg::BLUR_SUM_W'(win_reg[1][1]) << 2)
        + (rgg_pkg::BLUR_SUM_W'(win_reg[1][2]) << 1)
        + rgg_pkg::BLUR_SUM_W'(win_reg[2][0])
        + (rgg_pkg::BLUR_SUM_W'(win_reg[2][1]) << 1)
        + rgg_pkg::BLUR_SUM_W'(win_reg[2][2]);

    always_comb begin
        oq_in.col      = s_item_reg.col;
        oq_in.row      = s_item_reg.row;
        oq_in.gray     = s_item_reg.gray;
        oq_in.blur     = blur_sum[rgg_pkg::BLUR_SUM_W-1 -: rgg_pkg::PIX_W];
        oq_in.interior = s_item_reg.interior;
        oq_in.border   = s_item_reg.border;
        oq_in.done     = s_item_reg.done;
    end

    assign oq_push = sv_reg && (s_item_reg.interior || s_item_reg.border);

    // result port: interior result first, then the border one
    assign oq_head  = oq_slot_reg[oq_rptr_reg];
    assign m_valid  = (oq_count_reg != '0);
    assign show_int = oq_head.interior && !sub_reg;
    assign two_step = show_int && oq_head.border;
    assign m_accept = m_valid && m_ready;
    assign oq_pop   = m_accept && !two_step;
    assign sub_next = m_accept ? two_step : sub_reg;

    assign res_col       = show_int ? oq_head.col - rgg_pkg::COL_W'(1) : oq_head.col;
    assign m_out_col     = rgg_pkg::OUT_COL_W'(res_col);
    assign m_out_row     = show_int ? oq_head.row - rgg_pkg::ROW_W'(1) : oq_head.row;
    assign m_gray_value  = show_int ? oq_head.blur : oq_head.gray;
    assign m_is_border   = !show_int;
    assign m_last_in_run = !two_step;
    assign m_frame_done  = !show_int && oq_head.done;

    // result queue bookkeeping
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oq_wptr_reg  <= '0;
            oq_rptr_reg  <= '0;
            oq_count_reg <= '0;
            sub_reg      <= 1'b0;
        end else begin
            sub_reg <= sub_next;
            if (oq_push) begin
                oq_wptr_reg <= (oq_wptr_reg == rgg_pkg::OQ_PTR_W'(rgg_pkg::OQ_DEPTH - 1)) ?
                               '0 : oq_wptr_reg + rgg_pkg::OQ_PTR_W'(1);
            end
            if (oq_pop) begin
                oq_rptr_reg <= (oq_rptr_reg == rgg_pkg::OQ_PTR_W'(rgg_pkg::OQ_DEPTH - 1)) ?
                               '0 : oq_rptr_reg + rgg_pkg::OQ_PTR_W'(1);
            end
            if (oq_push && !oq_pop) begin
                oq_count_reg <= oq_count_reg + rgg_pkg::OQ_CNT_W'(1);
            end else if (oq_pop && !oq_push) begin
                oq_count_reg <= oq_count_reg - rgg_pkg::OQ_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (oq_push) begin
            oq_slot_reg[oq_wptr_reg] <= oq_in;
        end
    end

    // credit scheme keeps the result queue from overflowing
    assert property (@(posedge aclk) disable iff (!aresetn)
        oq_push && !oq_pop |-> oq_count_reg < rgg_pkg::OQ_CNT_W'(rgg_pkg::OQ_DEPTH))
        else $error("rgg_back: result queue overflow");

    // second half of a split word only exists for a two-result entry
    assert property (@(posedge aclk) disable iff (!aresetn)
        sub_reg |-> m_valid && oq_head.interior && oq_head.border)
        else $error("rgg_back: stray second result");

    // an interior centre needs two full rows and columns behind it
    assert property (@(posedge aclk) disable iff (!aresetn)
        qv_reg && q_item_reg.interior |->
            q_item_reg.row >= rgg_pkg::ROW_W'(2) && q_item_reg.col >= rgg_pkg::COL_W'(2))
        else $error("rgg_back: interior flag on an edge pixel");

    // the border result of a split entry is on offer right after the interior one
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_accept && two_step |=> m_valid && sub_reg)
        else $error("rgg_back: second result lost");

endmodule

// File: design/rgb_gray_gaussian3x3_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_gray_gaussian3x3_top
// Streaming rgb to 8-bit gray conversion with 3x3 smoothing of interior
// pixels; border pixels pass with their plain gray value.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------------
//   s_       | s_valid / s_ready  | s_red, s_green, s_blue
//   m_       | m_valid / m_ready  | m_out_col, m_out_row, m_gray_value,
//            |                    | m_is_border, m_last_in_run, m_frame_done
//   cfg_     | cfg_wr_en          | cfg_index, cfg_wr_data
//
// One pixel per cycle is taken in while s_ready allows it; pixels that yield
// two results (last column from row two on, and the last row from column two
// on) hold the result port for both result words, which sets the rate on those pixels.
// An input word passes through two luma stages, the queue, the line store
// read and the window sum on its way to the result port.
// Reset is synchronous, active low; the line stores are not cleared.
// Input and result sides stall independently through the front queue and
// the result queue, each four words deep.
// ----------------------------------------------------------------------------
module rgb_gray_gaussian3x3_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [rgg_pkg::PIX_W-1:0]        s_red,
    input  logic [rgg_pkg::PIX_W-1:0]        s_green,
    input  logic [rgg_pkg::PIX_W-1:0]        s_blue,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [rgg_pkg::OUT_COL_W-1:0]    m_out_col,
    output logic [rgg_pkg::ROW_W-1:0]        m_out_row,
    output logic [rgg_pkg::PIX_W-1:0]        m_gray_value,
    output logic                             m_is_border,
    output logic                             m_last_in_run,
    output logic                             m_frame_done,
    input  logic                             cfg_wr_en,
    input  logic [rgg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rgg_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);

    logic                             q_push;
    rgg_pkg::rgg_item_t               q_push_item;
    logic                             q_pop;
    logic                             q_not_empty;
    rgg_pkg::rgg_item_t               q_head;
    logic [rgg_pkg::Q_CNT_W-1:0]      q_fill;

    // counters, classification and luma
    rgg_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_red       (s_red),
        .s_green     (s_green),
        .s_blue      (s_blue),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .q_fill      (q_fill),
        .q_push      (q_push),
        .q_item      (q_push_item)
    );

    // decoupling queue
    rgg_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_push_item),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_item (q_head),
        .fill      (q_fill)
    );

    // line stores, window and results
    rgg_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_not_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_col     (m_out_col),
        .m_out_row     (m_out_row),
        .m_gray_value  (m_gray_value),
        .m_is_border   (m_is_border),
        .m_last_in_run (m_last_in_run),
        .m_frame_done  (m_frame_done)
    );

endmodule

// File: tb/sv/rgb_gray_gaussian3x3_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_gray_gaussian3x3_top_test
// Self-checking bench for the streaming rgb to gray converter with 3x3
// smoothing. Pixels go in through the valid/ready input under several idling
// patterns. A local model of the luma conversion, both line stores and the
// window predicts the result words of every accepted pixel. Each result word
// is checked in order against the oldest prediction. Frame geometry is
// changed only while the block is drained.
// ----------------------------------------------------------------------------
module rgb_gray_gaussian3x3_top_test;

    localparam int          CLK_PERIOD    = 10;
    localparam int          RESET_CYCLES  = 11;
    localparam int          SETTLE_CYCLES = 32;
    localparam int          TIMEOUT_NS    = 5_000_000;
    localparam int          REPORT_LIMIT  = 40;
    localparam int unsigned LINE_LEN      = 2048;
    localparam int unsigned DEFAULT_WIDTH  = 640;
    localparam int unsigned DEFAULT_HEIGHT = 480;

    // truncated q16 luma weights
    localparam int unsigned LUMA_RED   = 19595;
    localparam int unsigned LUMA_GREEN = 38469;
    localparam int unsigned LUMA_BLUE  = 7471;

    // register indexes with no register behind them
    localparam logic [rgg_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [rgg_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic [rgg_pkg::OUT_COL_W-1:0] col;
        logic [rgg_pkg::ROW_W-1:0]     row;
        logic [rgg_pkg::PIX_W-1:0]     gray;
        logic                          border;
        logic                          last;
        logic                          done;
    } gray_result_t;

    logic                             aclk;
    logic                             aresetn;
    logic                             s_valid;
    logic                             s_ready;
    logic [rgg_pkg::PIX_W-1:0]        s_red;
    logic [rgg_pkg::PIX_W-1:0]        s_green;
    logic [rgg_pkg::PIX_W-1:0]        s_blue;
    logic                             m_valid;
    logic                             m_ready = 1'b0;
    logic [rgg_pkg::OUT_COL_W-1:0]    m_out_col;
    logic [rgg_pkg::ROW_W-1:0]        m_out_row;
    logic [rgg_pkg::PIX_W-1:0]        m_gray_value;
    logic                             m_is_border;
    logic                             m_last_in_run;
    logic                             m_frame_done;
    logic                             cfg_wr_en;
    logic [rgg_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [rgg_pkg::CFG_DATA_W-1:0]   cfg_wr_data;

    // predictor state
    int unsigned  older_row [LINE_LEN] = '{default: 0};
    int unsigned  newer_row [LINE_LEN] = '{default: 0};
    int unsigned  win [3][3] = '{default: 0};
    int unsigned  col_next   = 0;
    int unsigned  row_next   = 0;
    int unsigned  width_reg  = DEFAULT_WIDTH;
    int unsigned  height_reg = DEFAULT_HEIGHT;

    gray_result_t pending_results [$];
    int           error_count   = 0;
    int unsigned  send_idle_pct = 0;
    int unsigned  stall_pct     = 0;

    rgb_gray_gaussian3x3_top u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_red         (s_red),
        .s_green       (s_green),
        .s_blue        (s_blue),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_col     (m_out_col),
        .m_out_row     (m_out_row),
        .m_gray_value  (m_gray_value),
        .m_is_border   (m_is_border),
        .m_last_in_run (m_last_in_run),
        .m_frame_done  (m_frame_done),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // result side back-pressure
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // run guard
    initial begin
        #TIMEOUT_NS;
        $display("rgb_gray_gaussian3x3_top: mismatch");
        $finish;
    end

    // effective geometry after clamping
    function automatic int unsigned active_width();
        if (width_reg == 0) return 1;
        if (width_reg > LINE_LEN) return LINE_LEN;
        return width_reg;
    endfunction

    function automatic int unsigned active_height();
        return (height_reg == 0) ? 1 : height_reg;
    endfunction

    // luma, line stores, window and the result words of one pixel
    task automatic predict_pixel(input logic [7:0] red, input logic [7:0] green,
                                 input logic [7:0] blue);
        int unsigned  w, h, c, r, gray, top, mid, sum;
        bit           is_inner, is_edge;
        gray_result_t inner, edge_word;
        w = active_width();
        h = active_height();
        c = col_next;
        r = row_next;
        gray = (LUMA_RED * 32'(red) + LUMA_GREEN * 32'(green) + LUMA_BLUE * 32'(blue)) >> 16;

        // rows not yet seen in this frame count as zero
        top = (r >= 2) ? older_row[c] : 0;
        mid = (r >= 1) ? newer_row[c] : 0;
        older_row[c] = mid;
        newer_row[c] = gray;

        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = gray;

        is_inner = (c >= 2) && (r >= 2);
        is_edge  = (r == 0) || (r == h - 1) || (c == 0) || (c == w - 1);

        // interior centre one up and one left, ahead of the arriving border pixel
        if (is_inner) begin
            sum = win[0][0] + 2 * win[0][1] + win[0][2]
                + 2 * win[1][0] + 4 * win[1][1] + 2 * win[1][2]
                + win[2][0] + 2 * win[2][1] + win[2][2];
            inner.col    = 11'(c - 1);
            inner.row    = 16'(r - 1);
            inner.gray   = 8'(sum >> 4);
            inner.border = 1'b0;
            inner.last   = !is_edge;
            inner.done   = 1'b0;
            pending_results.push_back(inner);
        end
        if (is_edge) begin
            edge_word.col    = 11'(c);
            edge_word.row    = 16'(r);
            edge_word.gray   = 8'(gray);
            edge_word.border = 1'b1;
            edge_word.last   = 1'b1;
            edge_word.done   = (c == w - 1) && (r == h - 1);
            pending_results.push_back(edge_word);
        end

        // raster position, wrapping at the end of the frame
        if (c + 1 >= w) begin
            col_next = 0;
            row_next = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_next = c + 1;
        end
    endtask

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            if (error_count < REPORT_LIMIT)
                $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    // compare every accepted result word with the oldest prediction
    always @(posedge aclk) begin : compare_results
        gray_result_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_results.size() == 0) begin
                if (error_count < REPORT_LIMIT)
                    $display("%0t ns: expected no word, got col %0d row %0d gray %0d",
                             $time, m_out_col, m_out_row, m_gray_value);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("out_col",     16'(want.col),    16'(m_out_col));
                check_field("out_row",     want.row,         m_out_row);
                check_field("gray_value",  16'(want.gray),   16'(m_gray_value));
                check_field("is_border",   16'(want.border), 16'(m_is_border));
                check_field("last_in_run", 16'(want.last),   16'(m_last_in_run));
                check_field("frame_done",  16'(want.done),   16'(m_frame_done));
            end
        end
    end

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            IDLE_SENDER: begin
                send_idle_pct = 47;
                stall_pct     = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct = 0;
                stall_pct     = 47;
            end
            default: begin
                send_idle_pct = 18;
                stall_pct     = 18;
            end
        endcase
    endtask

    // one pixel word through the input handshake, entered and left at a falling edge
    task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                              input logic [7:0] blue);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_red   <= red;
        s_green <= green;
        s_blue  <= blue;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        predict_pixel(red, green, blue);
        @(negedge aclk);
    endtask

    // component with extra weight on the extremes
    function automatic logic [7:0] pick_component();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_random_pixel();
        send_pixel(pick_component(), pick_component(), pick_component());
    endtask

    // stop input, let every predicted word out, then let the pipeline empty
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_register(input logic [rgg_pkg::CFG_IDX_W-1:0] index,
                                  input logic [rgg_pkg::CFG_DATA_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= index;
        cfg_wr_data <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
        // a real register write restarts the frame
        if (index == rgg_pkg::CFG_IMAGE_WIDTH) begin
            width_reg = 32'(data[11:0]);
            col_next  = 0;
            row_next  = 0;
        end else if (index == rgg_pkg::CFG_IMAGE_HEIGHT) begin
            height_reg = 32'(data);
            col_next   = 0;
            row_next   = 0;
        end
    endtask

    task automatic set_geometry(input logic [15:0] width_data, input logic [15:0] height_data);
        wait_drained();
        if ($urandom_range(1) == 0) begin
            write_register(rgg_pkg::CFG_IMAGE_WIDTH, width_data);
            write_register(rgg_pkg::CFG_IMAGE_HEIGHT, height_data);
        end else begin
            write_register(rgg_pkg::CFG_IMAGE_HEIGHT, height_data);
            write_register(rgg_pkg::CFG_IMAGE_WIDTH, width_data);
        end
    endtask

    // default 640 x 480 geometry straight out of reset
    task automatic test_reset_geometry();
        set_idling(IDLE_SENDER);
        repeat (645) send_random_pixel();
    endtask

    // extreme pixels, a small frame with interior, and the degenerate sizes
    task automatic test_directed_corners();
        logic [23:0] corners [12];
        set_idling(IDLE_NONE);
        corners = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
                    24'h0000FF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFF00,
                    24'h00FFFF, 24'hFF00FF, 24'h808080, 24'h010101};
        set_geometry(16'h0004, 16'h0003);
        foreach (corners[i]) send_pixel(corners[i][23:16], corners[i][15:8], corners[i][7:0]);

        // zero width and height act as one: every pixel is a whole frame
        set_geometry(16'hF000, 16'h0000);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'h00, 8'h00, 8'h00);

        // upper data bits of the width register are ignored
        set_geometry(16'hA002, 16'h0002);
        repeat (4) send_random_pixel();

        set_geometry(16'h0001, 16'h0003);
        repeat (3) send_random_pixel();
    endtask

    // a write restarts the frame; writes to spare indexes change nothing
    task automatic test_register_writes();
        set_idling(IDLE_BOTH);
        set_geometry(16'h0005, 16'h0004);
        repeat (7) send_random_pixel();
        wait_drained();
        write_register(rgg_pkg::CFG_IMAGE_HEIGHT, 16'h0004);
        repeat (9) send_random_pixel();
        wait_drained();
        write_register(CFG_SPARE_A, 16'($urandom_range(16'hFFFF)));
        write_register(CFG_SPARE_B, 16'($urandom_range(16'hFFFF)));
        repeat (11) send_random_pixel();
        wait_drained();
        write_register(rgg_pkg::CFG_IMAGE_WIDTH, 16'h0005);
        repeat (25) send_random_pixel();
    endtask

    // width above the line length clamps to it; the tallest height
    task automatic test_width_clamp();
        set_idling(IDLE_RECEIVER);
        set_geometry(16'hFFFF, 16'hFFFF);
        repeat (300) send_random_pixel();
    endtask

    // random geometries, mostly whole frames, some cut short by a new write
    task automatic test_random_frames(input int unsigned budget);
        int unsigned sent, w_pick, h_pick, frame_len, n;
        int          phase;
        sent  = 0;
        phase = 0;
        while (sent < budget) begin
            set_idling(idle_mode_t'(phase % 4));
            phase++;
            case ($urandom_range(9))
                0: w_pick = 0;
                1: w_pick = $urandom_range(1, 2);
                default: w_pick = $urandom_range(3, 12);
            endcase
            case ($urandom_range(9))
                0: h_pick = 0;
                1: h_pick = $urandom_range(1, 2);
                default: h_pick = $urandom_range(3, 8);
            endcase
            set_geometry({4'($urandom_range(15)), 12'(w_pick)}, 16'(h_pick));
            frame_len = active_width() * active_height();
            if ($urandom_range(4) == 0)
                n = $urandom_range(1, frame_len);
            else
                n = frame_len * $urandom_range(1, 2);
            repeat (n) send_random_pixel();
            sent += n;
        end
    endtask

    // test sequence
    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_red       = '0;
        s_green     = '0;
        s_blue      = '0;
        cfg_wr_en   = 1'b0;
        cfg_index   = rgg_pkg::CFG_IMAGE_WIDTH;
        cfg_wr_data = '0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_geometry();
        test_directed_corners();
        test_register_writes();
        test_width_clamp();
        test_random_frames(580);
        wait_drained();

        if (error_count == 0) begin
            $display("rgb_gray_gaussian3x3_top: match");
        end else begin
            $display("rgb_gray_gaussian3x3_top: mismatch");
        end
        $finish;
    end

endmodule
